// ===== sv/msps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, register codes and constants of the multi-servo pulse sequencer.
// No dependencies; every other file but msps_skid.sv uses this package.
package msps_pkg;

	localparam int SLOTS = 24;
	localparam int SLOT_W = 5;
	localparam int CNT_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_GROUPS = 2;

	localparam int DEF_SERVOS_PER_GROUP = 12;
	localparam int DEF_GROUPS = 2;
	localparam int DEF_GUARD_TICKS = 4;

	localparam logic [CNT_W-1:0] COUNTER_TOP = 16'hFFFF;
	localparam logic [CNT_W-1:0] RESET_REFRESH = 16'd20000;
	localparam logic [CNT_W-1:0] RESET_START_DELAY = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_SERVO_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_ENABLE = 2'd3;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef struct packed {
		logic action;
		logic [SLOT_W-1:0] servo_slot;
		logic [CNT_W-1:0] pulse_ticks;
		logic servo_active;
	} item_t;

	typedef struct packed {
		logic [SLOTS-1:0] pin_levels;
		logic [CNT_W-1:0] counter_value;
	} result_t;

	typedef struct packed {
		logic we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] counter;
		logic [SLOTS-1:0] pins;
		logic [MAX_GROUPS-1:0] group_en;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/msps_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for input items and result words.
// Depends on msps_pkg for field widths.
interface msps_item_if;
	logic valid;
	logic ready;
	logic action;
	logic [msps_pkg::SLOT_W-1:0] servo_slot;
	logic [msps_pkg::CNT_W-1:0] pulse_ticks;
	logic servo_active;

	modport source (output valid, action, servo_slot, pulse_ticks, servo_active, input ready);
	modport sink (input valid, action, servo_slot, pulse_ticks, servo_active, output ready);
endinterface

interface msps_result_if;
	logic valid;
	logic ready;
	logic [msps_pkg::SLOTS-1:0] pin_levels;
	logic [msps_pkg::CNT_W-1:0] counter_value;

	modport source (output valid, pin_levels, counter_value, input ready);
	modport sink (input valid, pin_levels, counter_value, output ready);
endinterface
`default_nettype wire

// ===== sv/msps_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Servo setting table: pulse widths per group and position, active flag per slot.
// Depends on msps_pkg.
module msps_table #(
	parameter int SERVOS_PER_GROUP = msps_pkg::DEF_SERVOS_PER_GROUP,
	parameter int GROUPS = msps_pkg::DEF_GROUPS,
	localparam int PW = (SERVOS_PER_GROUP > 1) ? $clog2(SERVOS_PER_GROUP) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [msps_pkg::SLOT_W-1:0] wr_slot,
	input wire logic [msps_pkg::CNT_W-1:0] wr_pulse,
	input wire logic wr_active,
	input wire logic [GROUPS-1:0][PW-1:0] rd_pos,
	output logic [GROUPS-1:0][msps_pkg::CNT_W-1:0] rd_pulse,
	output logic [msps_pkg::SLOTS-1:0] active
);
	import msps_pkg::*;

	logic [GROUPS-1:0][SERVOS_PER_GROUP-1:0][CNT_W-1:0] pulse_q;
	logic [SLOTS-1:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= '0;
			active_q <= '0;
		end else if (wr_en && int'(wr_slot) < SLOTS) begin
			for (int g = 0; g < GROUPS; g++) begin
				for (int p = 0; p < SERVOS_PER_GROUP; p++) begin
					if (int'(wr_slot) == g * SERVOS_PER_GROUP + p) begin
						pulse_q[g][p] <= wr_pulse;
					end
				end
			end
			active_q[wr_slot] <= wr_active;
		end
	end

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			rd_pulse[g] = pulse_q[g][rd_pos[g]];
		end
	end

	assign active = active_q;

endmodule
`default_nettype wire

// ===== sv/msps_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencing state: shared down-counter, group compares and positions, pin register,
// configuration registers and the single-pass next-state logic. Depends on msps_pkg.
module msps_core #(
	parameter int SERVOS_PER_GROUP = msps_pkg::DEF_SERVOS_PER_GROUP,
	parameter int GROUPS = msps_pkg::DEF_GROUPS,
	parameter int GUARD_TICKS = msps_pkg::DEF_GUARD_TICKS,
	localparam int PW = (SERVOS_PER_GROUP > 1) ? $clog2(SERVOS_PER_GROUP) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire msps_pkg::cfg_wr_t cfg,
	input wire logic step,
	input wire msps_pkg::item_t item,
	output msps_pkg::result_t res,
	output msps_pkg::status_t status,
	output logic [GROUPS-1:0][PW-1:0] rd_pos,
	input wire logic [GROUPS-1:0][msps_pkg::CNT_W-1:0] rd_pulse,
	input wire logic [msps_pkg::SLOTS-1:0] active
);
	import msps_pkg::*;

	localparam int SW = 6;

	logic [CNT_W-1:0] counter_q;
	logic [SLOTS-1:0] pins_q;
	logic [GROUPS-1:0] refresh_q;
	logic [GROUPS-1:0][PW-1:0] pos_q;
	logic [GROUPS-1:0][CNT_W-1:0] match_q;
	logic [SLOT_W-1:0] servo_count_q;
	logic [CNT_W-1:0] refresh_ticks_q;
	logic [CNT_W-1:0] start_delay_q;
	logic [MAX_GROUPS-1:0] group_en_q;

	logic [GROUPS-1:0] en;
	logic [GROUPS-1:0] en_new;
	logic [CNT_W-1:0] cnt_dec;
	logic [GROUPS-1:0] hit;
	logic [GROUPS-1:0][PW:0] npos;

	logic [CNT_W-1:0] cnt_n;
	logic [SLOTS-1:0] pins_n;
	logic [GROUPS-1:0] refresh_n;
	logic [GROUPS-1:0][PW-1:0] pos_n;
	logic [GROUPS-1:0][CNT_W-1:0] match_n;
	logic busy;
	logic [SW-1:0] cur_s;
	logic [SW-1:0] nxt_s;
	logic [CNT_W:0] elapsed;

	logic [CNT_W-1:0] cfg_cnt;
	logic [GROUPS-1:0][CNT_W-1:0] cfg_match;

	function automatic logic slot_exists(input logic [SW-1:0] s, input logic [SLOT_W-1:0] n);
		return (int'(s) < SLOTS) && (s < {1'b0, n});
	endfunction

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			en[g] = group_en_q[g];
			en_new[g] = cfg.data[g];
			npos[g] = refresh_q[g] ? '0 : ({1'b0, pos_q[g]} + (PW+1)'(1));
			rd_pos[g] = npos[g][PW-1:0];
		end
	end

	assign cnt_dec = counter_q - CNT_W'(1);

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			hit[g] = en[g] && (cnt_dec == match_q[g]);
		end
	end

	always_comb begin
		cnt_n = counter_q;
		pins_n = pins_q;
		refresh_n = refresh_q;
		pos_n = pos_q;
		match_n = match_q;
		busy = 1'b0;
		cur_s = '0;
		nxt_s = '0;
		elapsed = '0;
		if (item.action == ACT_TICK && en != '0) begin
			cnt_n = cnt_dec;
			for (int g = 0; g < GROUPS; g++) begin
				if (hit[g]) begin
					busy = 1'b0;
					for (int h = 0; h < GROUPS; h++) begin
						if (h != g && !refresh_n[h]) busy = 1'b1;
					end
					if (!(refresh_q[g] && busy)) begin
						if (refresh_q[g]) begin
							cnt_n = COUNTER_TOP;
						end else begin
							cur_s = SW'(g * SERVOS_PER_GROUP) + SW'(pos_q[g]);
							if (slot_exists(cur_s, servo_count_q) && active[cur_s[SLOT_W-1:0]])
								pins_n[cur_s[SLOT_W-1:0]] = 1'b0;
						end
						nxt_s = SW'(g * SERVOS_PER_GROUP) + SW'(npos[g]);
						if (npos[g] < (PW+1)'(SERVOS_PER_GROUP) &&
						    slot_exists(nxt_s, servo_count_q)) begin
							if (active[nxt_s[SLOT_W-1:0]]) pins_n[nxt_s[SLOT_W-1:0]] = 1'b1;
							refresh_n[g] = 1'b0;
							pos_n[g] = npos[g][PW-1:0];
							match_n[g] = cnt_n - rd_pulse[g];
						end else begin
							refresh_n[g] = 1'b1;
							elapsed = {1'b0, COUNTER_TOP - cnt_n};
							if (elapsed + (CNT_W+1)'(GUARD_TICKS) < {1'b0, refresh_ticks_q})
								match_n[g] = COUNTER_TOP - refresh_ticks_q;
							else
								match_n[g] = cnt_n - CNT_W'(GUARD_TICKS);
						end
					end
				end
			end
		end
	end

	always_comb begin
		cfg_cnt = (en == '0 && en_new != '0) ? COUNTER_TOP : counter_q;
		for (int g = 0; g < GROUPS; g++) begin
			cfg_match[g] = (en_new[g] && !en[g]) ? (cfg_cnt - start_delay_q) : match_q[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= COUNTER_TOP;
			pins_q <= '0;
			refresh_q <= '1;
			pos_q <= '0;
			for (int g = 0; g < GROUPS; g++) match_q[g] <= COUNTER_TOP - RESET_START_DELAY;
			servo_count_q <= '0;
			refresh_ticks_q <= RESET_REFRESH;
			start_delay_q <= RESET_START_DELAY;
			group_en_q <= '0;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_SERVO_COUNT: servo_count_q <= cfg.data[SLOT_W-1:0];
				REG_REFRESH_TICKS: refresh_ticks_q <= cfg.data[CNT_W-1:0];
				REG_START_DELAY: start_delay_q <= cfg.data[CNT_W-1:0];
				REG_GROUP_ENABLE: begin
					group_en_q <= cfg.data[MAX_GROUPS-1:0];
					counter_q <= cfg_cnt;
					match_q <= cfg_match;
				end
				default: ;
			endcase
		end else if (step && item.action == ACT_TICK) begin
			counter_q <= cnt_n;
			pins_q <= pins_n;
			refresh_q <= refresh_n;
			pos_q <= pos_n;
			match_q <= match_n;
		end
	end

	assign res.pin_levels = pins_n;
	assign res.counter_value = cnt_n;
	assign status.counter = counter_q;
	assign status.pins = pins_q;
	assign status.group_en = MAX_GROUPS'(en);

endmodule
`default_nettype wire

// ===== sv/msps_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-entry result buffer between the result stage and the output channel.
// Generic width; no package dependency.
module msps_skid #(
	parameter int W = 40
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [W-1:0] push_data,
	output logic room,
	output logic valid,
	output logic [W-1:0] data,
	input wire logic pop
);
	logic [1:0][W-1:0] mem_q;
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic take;

	assign valid = (count_q != 2'd0);
	assign room = (count_q != 2'd2);
	assign take = valid && pop;
	assign data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (take) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== sv/multi_servo_pulse_sequencer.sv =====
// Multi-servo pulse sequencer. Each input word is either one prescaled timer tick or
// a write of one servo's pulse width and active flag; every word yields one result
// word with the 24 pin levels and the shared down-counter after it. The block takes
// one word per clock while the output buffer has room: a word is registered in the
// input stage, then the next-state logic of counter, group compares and pin register
// updates all state and pushes the result into a two-entry output buffer, from which
// it is offered. Throughput is set by that single state-update pass; the output buffer
// keeps input flowing while a result waits. Configuration writes land at once and
// belong to idle periods only.
`timescale 1ns / 1ps
`default_nettype none
module multi_servo_pulse_sequencer #(
	parameter int SERVOS_PER_GROUP = msps_pkg::DEF_SERVOS_PER_GROUP,
	parameter int GROUPS = msps_pkg::DEF_GROUPS,
	parameter int GUARD_TICKS = msps_pkg::DEF_GUARD_TICKS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [msps_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [msps_pkg::CFG_W-1:0] cfg_data,
	msps_item_if.sink item,
	msps_result_if.source result
);
	import msps_pkg::*;

	localparam int PW = (SERVOS_PER_GROUP > 1) ? $clog2(SERVOS_PER_GROUP) : 1;

	logic valid_s1;
	item_t item_s1;
	logic adv;
	logic room;
	logic out_valid;
	logic [$bits(result_t)-1:0] out_data;
	result_t res;
	result_t out_word;
	status_t status;
	cfg_wr_t cfg;
	logic [GROUPS-1:0][PW-1:0] rd_pos;
	logic [GROUPS-1:0][CNT_W-1:0] rd_pulse;
	logic [SLOTS-1:0] active;

	assign adv = valid_s1 && room;
	assign item.ready = !valid_s1 || adv;

	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action <= item.action;
			item_s1.servo_slot <= item.servo_slot;
			item_s1.pulse_ticks <= item.pulse_ticks;
			item_s1.servo_active <= item.servo_active;
		end
	end

	msps_table #(
		.SERVOS_PER_GROUP(SERVOS_PER_GROUP),
		.GROUPS(GROUPS)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(adv && item_s1.action == ACT_WRITE),
		.wr_slot(item_s1.servo_slot),
		.wr_pulse(item_s1.pulse_ticks),
		.wr_active(item_s1.servo_active),
		.rd_pos(rd_pos),
		.rd_pulse(rd_pulse),
		.active(active)
	);

	msps_core #(
		.SERVOS_PER_GROUP(SERVOS_PER_GROUP),
		.GROUPS(GROUPS),
		.GUARD_TICKS(GUARD_TICKS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(adv),
		.item(item_s1),
		.res(res),
		.status(status),
		.rd_pos(rd_pos),
		.rd_pulse(rd_pulse),
		.active(active)
	);

	msps_skid #(
		.W($bits(result_t))
	) u_skid (
		.clk(clk),
		.arst_n(arst_n),
		.push(adv),
		.push_data(res),
		.room(room),
		.valid(out_valid),
		.data(out_data),
		.pop(result.ready)
	);

	assign out_word = result_t'(out_data);
	assign result.valid = out_valid;
	assign result.pin_levels = out_word.pin_levels;
	assign result.counter_value = out_word.counter_value;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result.valid)
		else $error("processed word left no result");

	a_write_keeps_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.action == ACT_WRITE && !cfg_we)
		|=> ($stable(status.counter) && $stable(status.pins)))
		else $error("setting write changed counter or pins");

	a_stopped_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.action == ACT_TICK && status.group_en == '0 && !cfg_we)
		|=> $stable(status.counter))
		else $error("tick moved counter with all groups disabled");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("input stalled with empty input stage");

endmodule
`default_nettype wire

// ===== sim/multi_servo_pulse_sequencer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the multi-servo pulse sequencer: follows register writes and accepted
// words, predicts each result word and compares it with what the block returns.
// Depends on msps_pkg and the channel interfaces of msps_ifs.sv.
module multi_servo_pulse_sequencer_checker
	import msps_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	msps_item_if item,
	msps_result_if result,
	output int mismatches,
	output int outstanding
);

	localparam int PER_GROUP = DEF_SERVOS_PER_GROUP;
	localparam int NGROUPS = DEF_GROUPS;
	localparam int GUARD = DEF_GUARD_TICKS;
	localparam logic [MAX_GROUPS-1:0] GROUP_MASK = MAX_GROUPS'((1 << NGROUPS) - 1);

	logic [SLOT_W-1:0] servos_in_use;
	logic [CNT_W-1:0] frame_ticks;
	logic [CNT_W-1:0] lead_ticks;
	logic [MAX_GROUPS-1:0] group_on;
	logic [CNT_W-1:0] timer;
	logic [CNT_W-1:0] compare [MAX_GROUPS];
	int position [MAX_GROUPS];
	logic [CNT_W-1:0] width_of [SLOTS];
	logic active_of [SLOTS];
	logic [SLOTS-1:0] levels;
	result_t awaited [$];

	function automatic bit servo_present(input int s);
		return s < SLOTS && s < servos_in_use;
	endfunction

	task automatic service_group(input int g);
		int base;
		int p;
		int s;
		int unsigned elapsed;
		base = g * PER_GROUP;
		p = position[g];
		if (p < 0) begin
			// wait in refresh while the partner group still runs its servos
			if (NGROUPS == 2 && position[g ^ 1] >= 0)
				return;
			timer = COUNTER_TOP;
		end else begin
			s = base + p;
			if (servo_present(s) && active_of[s])
				levels[s] = 1'b0;
		end
		p++;
		s = base + p;
		if (servo_present(s) && p < PER_GROUP) begin
			if (active_of[s])
				levels[s] = 1'b1;
			position[g] = p;
			compare[g] = timer - width_of[s];
		end else begin
			elapsed = COUNTER_TOP - timer;
			position[g] = -1;
			if (elapsed + GUARD < frame_ticks)
				compare[g] = COUNTER_TOP - frame_ticks;
			else
				compare[g] = timer - CNT_W'(GUARD);
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		logic [MAX_GROUPS-1:0] was;
		logic [MAX_GROUPS-1:0] now;
		int g;
		case (idx)
			REG_SERVO_COUNT: servos_in_use = value[SLOT_W-1:0];
			REG_REFRESH_TICKS: frame_ticks = value;
			REG_START_DELAY: lead_ticks = value;
			REG_GROUP_ENABLE: begin
				was = group_on & GROUP_MASK;
				group_on = value[MAX_GROUPS-1:0];
				now = group_on & GROUP_MASK;
				if (was == '0 && now != '0)
					timer = COUNTER_TOP;
				for (g = 0; g < NGROUPS; g++)
					if (now[g] && !was[g])
						compare[g] = timer - lead_ticks;
			end
			default: ;
		endcase
	endtask

	task automatic step_word(input item_t w);
		logic [MAX_GROUPS-1:0] live;
		logic [MAX_GROUPS-1:0] hit;
		result_t r;
		int g;
		hit = '0;
		if (w.action == ACT_WRITE) begin
			if (w.servo_slot < SLOTS) begin
				width_of[w.servo_slot] = w.pulse_ticks;
				active_of[w.servo_slot] = w.servo_active;
			end
		end else begin
			live = group_on & GROUP_MASK;
			if (live != '0) begin
				timer = timer - 1'b1;
				// judge both matches first, then service in group order
				for (g = 0; g < NGROUPS; g++)
					hit[g] = live[g] && timer == compare[g];
				for (g = 0; g < NGROUPS; g++)
					if (hit[g])
						service_group(g);
			end
		end
		r.pin_levels = levels;
		r.counter_value = timer;
		awaited.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t w;
		result_t want;
		int i;
		if (!arst_n) begin
			servos_in_use = '0;
			frame_ticks = RESET_REFRESH;
			lead_ticks = RESET_START_DELAY;
			group_on = '0;
			timer = COUNTER_TOP;
			for (i = 0; i < MAX_GROUPS; i++) begin
				compare[i] = COUNTER_TOP - RESET_START_DELAY;
				position[i] = -1;
			end
			for (i = 0; i < SLOTS; i++) begin
				width_of[i] = '0;
				active_of[i] = 1'b0;
			end
			levels = '0;
			awaited.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (awaited.size() == 0) begin
					$error("result word with nothing outstanding: pin_levels %h counter_value %h",
						result.pin_levels, result.counter_value);
					mismatches++;
				end else begin
					want = awaited.pop_front();
					if (result.pin_levels !== want.pin_levels) begin
						$error("pin_levels: expected %h, got %h", want.pin_levels, result.pin_levels);
						mismatches++;
					end
					if (result.counter_value !== want.counter_value) begin
						$error("counter_value: expected %h, got %h", want.counter_value,
							result.counter_value);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				write_register(cfg_index, cfg_data);
			if (item.valid && item.ready) begin
				w.action = item.action;
				w.servo_slot = item.servo_slot;
				w.pulse_ticks = item.pulse_ticks;
				w.servo_active = item.servo_active;
				step_word(w);
			end
			outstanding = awaited.size();
		end
	end

endmodule

// ===== sim/multi_servo_pulse_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Top of the sequencer testbench: clock, reset, register writes and word stimulus,
// with the scoreboard from multi_servo_pulse_sequencer_checker.sv beside the block.
// Depends on msps_pkg, msps_ifs.sv and the block itself.
module multi_servo_pulse_sequencer_tb;
	import msps_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int mismatches;
	int outstanding;
	int idle_pct = 0;
	int stall_pct = 0;

	msps_item_if item ();
	msps_result_if result ();

	multi_servo_pulse_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item),
		.result(result)
	);

	multi_servo_pulse_sequencer_checker pulse_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item),
		.result(result),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			result.ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic offer(input item_t w);
		logic taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			item.valid = 1'b0;
			@(negedge clk);
		end
		item.valid = 1'b1;
		item.action = w.action;
		item.servo_slot = w.servo_slot;
		item.pulse_ticks = w.pulse_ticks;
		item.servo_active = w.servo_active;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = item.ready;
			@(negedge clk);
		end
	endtask

	task automatic tick();
		item_t w;
		w = item_t'($urandom);
		w.action = ACT_TICK;
		offer(w);
	endtask

	task automatic servo_write(input int slot, input logic [CNT_W-1:0] width, input logic on);
		item_t w;
		w.action = ACT_WRITE;
		w.servo_slot = slot[SLOT_W-1:0];
		w.pulse_ticks = width;
		w.servo_active = on;
		offer(w);
	endtask

	// hold off until every result word is back
	task automatic settle();
		item.valid = 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [CNT_W-1:0] pick_width();
		int r;
		r = $urandom_range(0, 39);
		if (r == 0)
			return '0;
		if (r == 1)
			return CNT_W'($urandom);
		return CNT_W'($urandom_range(1, 10));
	endfunction

	task automatic run_phase(input int words, input int shape);
		int slot;
		int r;
		settle();
		if (shape == 1) begin
			reg_write(REG_SERVO_COUNT, CFG_W'(SLOTS));
			reg_write(REG_REFRESH_TICKS, 16'hFFFF);
			reg_write(REG_START_DELAY, 16'hFFFF);
		end else if (shape == 2) begin
			reg_write(REG_SERVO_COUNT, '0);
			reg_write(REG_REFRESH_TICKS, '0);
			reg_write(REG_START_DELAY, '0);
		end else begin
			reg_write(REG_SERVO_COUNT, CFG_W'($urandom_range(0, 5) == 0 ?
				$urandom_range(0, SLOTS) : $urandom_range(13, SLOTS)));
			reg_write(REG_REFRESH_TICKS, CFG_W'($urandom_range(0, 9) == 0 ?
				$urandom_range(0, 16'hFFFF) : $urandom_range(0, 120)));
			reg_write(REG_START_DELAY,
				CFG_W'($urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 20)));
		end
		if ($urandom_range(0, 1) == 1)
			reg_write(REG_GROUP_ENABLE, '0);
		for (slot = 0; slot < SLOTS; slot++)
			if ($urandom_range(0, 4) != 0)
				servo_write(slot, pick_width(), $urandom_range(0, 7) != 0);
		settle();
		r = $urandom_range(0, 9);
		reg_write(REG_GROUP_ENABLE,
			CFG_W'(shape == 1 ? 3 : r < 1 ? 0 : r < 3 ? 1 : r < 5 ? 2 : 3));
		repeat (words) begin
			r = $urandom_range(0, 99);
			if (r < 88) begin
				tick();
			end else if (r < 98) begin
				servo_write($urandom_range(0, 31), pick_width(), 1'($urandom_range(0, 1)));
			end else if (r == 98) begin
				settle();
				tick();
			end else begin
				servo_write($urandom_range(0, 31), CNT_W'($urandom), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		int p;
		int m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.action = ACT_TICK;
		item.servo_slot = '0;
		item.pulse_ticks = '0;
		item.servo_active = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// timer stopped, ignored slots, extremes of the width, inactive servo
		tick();
		servo_write(31, 16'hFFFF, 1'b1);
		servo_write(24, 16'h0000, 1'b1);
		servo_write(0, 16'hFFFF, 1'b0);
		servo_write(0, 16'd3, 1'b1);
		servo_write(1, 16'd2, 1'b0);
		servo_write(12, 16'd1, 1'b1);
		servo_write(23, 16'd5, 1'b1);
		settle();
		// both groups match together; group 1 then waits in refresh
		reg_write(REG_SERVO_COUNT, 16'd2);
		reg_write(REG_REFRESH_TICKS, 16'd10);
		reg_write(REG_START_DELAY, 16'd2);
		reg_write(REG_GROUP_ENABLE, 16'd3);
		repeat (16) tick();

		for (p = 0; p < 12; p++) begin
			settle();
			m = p % 4;
			idle_pct = (m == 1) ? 79 : (m == 3) ? 24 : 0;
			stall_pct = (m == 2) ? 79 : (m == 3) ? 24 : 0;
			run_phase(100, p == 3 ? 2 : p == 7 ? 1 : 0);
		end

		settle();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
